[hdl/anp_pkg.sv]
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types, codes and helpers of the ASCII number parser.
// ----------------------------------------------------------------------------
`default_nettype none

package anp_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int ACC_W      = 64;
    localparam int BASE_W     = 6;
    localparam int TWIDTH_W   = 7;
    localparam int FRAC_W     = 6;
    localparam int STATUS_W   = 3;
    localparam int CLS_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [BASE_W-1:0]   BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0]   BASE_MAX   = 6'd36;
    localparam logic [FRAC_W-1:0]   FRAC_LIMIT = 6'd63;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIGNED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_ALLOWED = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_CLEAN   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PARTIAL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POINT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NEGU    = 3'd5;

    // character classes
    localparam logic [CLS_W-1:0] CL_NUL   = 3'd0;
    localparam logic [CLS_W-1:0] CL_SPACE = 3'd1;
    localparam logic [CLS_W-1:0] CL_MINUS = 3'd2;
    localparam logic [CLS_W-1:0] CL_PLUS  = 3'd3;
    localparam logic [CLS_W-1:0] CL_POINT = 3'd4;
    localparam logic [CLS_W-1:0] CL_DIGIT = 3'd5;
    localparam logic [CLS_W-1:0] CL_OTHER = 3'd6;

    typedef struct packed {
        logic [BASE_W-1:0]   number_base;
        logic [TWIDTH_W-1:0] target_width;
        logic                target_signed;
        logic                fraction_allowed;
    } t_cfg;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [BASE_W-1:0] digit;
        logic              is_last;
    } t_dec;

    typedef struct packed {
        logic [ACC_W-1:0]    acc;
        logic                overflow;
        logic                digit_seen;
        logic                negative;
        logic [FRAC_W-1:0]   frac;
        logic [STATUS_W-1:0] status;
    } t_snap;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/anp_in_if.sv]
// ----------------------------------------------------------------------------
// anp_in_if
// Character channel: one byte of text per item with a last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface anp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       is_last;

    modport source (output valid, output char_byte, output is_last, input ready);
    modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

`default_nettype wire

[hdl/anp_out_if.sv]
// ----------------------------------------------------------------------------
// anp_out_if
// Result channel: parsed value, fraction digit count and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface anp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] parsed_value;
    logic [5:0]  fraction_digits;
    logic        parse_ok;
    logic [2:0]  status_code;

    modport source (output valid, output parsed_value, output fraction_digits,
                    output parse_ok, output status_code, input ready);
    modport sink   (input valid, input parsed_value, input fraction_digits,
                    input parse_ok, input status_code, output ready);
endinterface

`default_nettype wire

[hdl/anp_decode.sv]
// ----------------------------------------------------------------------------
// anp_decode
// Input register: classifies each incoming character and its digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module anp_decode
    import anp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_cfg    i_cfg,
    anp_in_if.sink       i_item,
    input  wire          i_consume,
    output logic         o_vld,
    output t_dec         o_dec
);

    logic              r_vld;
    t_dec              r_dec;
    t_dec              n_dec;
    logic [BASE_W-1:0] base_eff;
    logic [7:0]        c;
    logic [7:0]        dval;
    logic              is_alnum;

    assign base_eff = clamp_base(i_cfg.number_base);
    assign c        = i_item.char_byte;

    always_comb begin
        dval     = 8'd99;
        is_alnum = 1'b0;
        if (c >= "0" && c <= "9") begin
            dval     = c - 8'd48;
            is_alnum = 1'b1;
        end else if (c >= "A" && c <= "Z") begin
            dval     = c - 8'd55;
            is_alnum = 1'b1;
        end else if (c >= "a" && c <= "z") begin
            dval     = c - 8'd87;
            is_alnum = 1'b1;
        end

        n_dec.digit   = dval[BASE_W-1:0];
        n_dec.is_last = i_item.is_last;
        if (c == 8'd0) begin
            n_dec.cls = CL_NUL;
        end else if (c <= 8'd32 || c == 8'd127) begin
            n_dec.cls = CL_SPACE;
        end else if (c == "-") begin
            n_dec.cls = CL_MINUS;
        end else if (c == "+") begin
            n_dec.cls = CL_PLUS;
        end else if (c == "." || c == ",") begin
            n_dec.cls = CL_POINT;
        end else if (is_alnum && dval < {2'b00, base_eff}) begin
            n_dec.cls = CL_DIGIT;
        end else begin
            n_dec.cls = CL_OTHER;
        end
    end

    assign i_item.ready = !r_vld || i_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_vld <= i_item.valid;
        end
        if (i_item.ready && i_item.valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_vld = r_vld;
    assign o_dec = r_dec;

endmodule

`default_nettype wire

[hdl/anp_accum.sv]
// ----------------------------------------------------------------------------
// anp_accum
// Parse state and multiply-add accumulator; hands a snapshot on the last item.
// ----------------------------------------------------------------------------
`default_nettype none

module anp_accum
    import anp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire          i_dec_vld,
    input  wire t_dec    i_dec,
    output logic         o_consume,
    input  wire          i_snap_take,
    output logic         o_snap_vld,
    output t_snap        o_snap
);

    localparam int PROD_W = ACC_W + BASE_W;

    logic [ACC_W-1:0]    r_acc,      n_acc;
    logic                r_ovf,      n_ovf;
    logic                r_seen,     n_seen;
    logic                r_neg,      n_neg;
    logic                r_point,    n_point;
    logic [FRAC_W-1:0]   r_frac,     n_frac;
    logic                r_stopped,  n_stopped;
    logic [STATUS_W-1:0] r_status,   n_status;
    logic                r_snap_vld;
    t_snap               r_snap;
    logic [PROD_W-1:0]   prod;
    logic [BASE_W-1:0]   base_eff;
    logic                snap_free;

    assign base_eff = clamp_base(i_cfg.number_base);
    assign prod     = PROD_W'(r_acc) * PROD_W'(base_eff) + PROD_W'(i_dec.digit);

    always_comb begin
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_seen    = r_seen;
        n_neg     = r_neg;
        n_point   = r_point;
        n_frac    = r_frac;
        n_stopped = r_stopped;
        n_status  = r_status;
        if (!r_stopped) begin
            unique case (i_dec.cls)
                CL_NUL: begin
                    n_stopped = 1'b1;
                end
                CL_SPACE: begin
                    if (r_seen) begin
                        n_stopped = 1'b1;
                        n_status  = ST_PARTIAL;
                    end
                end
                CL_MINUS, CL_PLUS: begin
                    if (r_seen) begin
                        n_stopped = 1'b1;
                        n_status  = ST_PARTIAL;
                    end else if (i_dec.cls == CL_MINUS) begin
                        n_neg = !r_neg;
                    end
                end
                CL_POINT: begin
                    if (!r_seen || r_point) begin
                        n_stopped = 1'b1;
                        n_status  = ST_PARTIAL;
                    end else if (!i_cfg.fraction_allowed) begin
                        n_stopped = 1'b1;
                        n_status  = ST_POINT;
                    end else begin
                        n_point = 1'b1;
                    end
                end
                CL_DIGIT: begin
                    n_seen = 1'b1;
                    if (r_ovf || prod[PROD_W-1:ACC_W] != '0) begin
                        n_ovf = 1'b1;
                        n_acc = '1;
                    end else begin
                        n_acc = prod[ACC_W-1:0];
                    end
                    if (r_point && r_frac < FRAC_LIMIT) begin
                        n_frac = r_frac + FRAC_W'(1);
                    end
                end
                default: begin
                    n_stopped = 1'b1;
                    n_status  = ST_PARTIAL;
                end
            endcase
        end
    end

    assign snap_free = !r_snap_vld || i_snap_take;
    assign o_consume = i_dec_vld && (!i_dec.is_last || snap_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_seen     <= 1'b0;
            r_neg      <= 1'b0;
            r_point    <= 1'b0;
            r_frac     <= '0;
            r_stopped  <= 1'b0;
            r_status   <= ST_CLEAN;
            r_snap_vld <= 1'b0;
        end else begin
            if (o_consume && i_dec.is_last) begin
                r_acc     <= '0;
                r_ovf     <= 1'b0;
                r_seen    <= 1'b0;
                r_neg     <= 1'b0;
                r_point   <= 1'b0;
                r_frac    <= '0;
                r_stopped <= 1'b0;
                r_status  <= ST_CLEAN;
            end else if (o_consume) begin
                r_acc     <= n_acc;
                r_ovf     <= n_ovf;
                r_seen    <= n_seen;
                r_neg     <= n_neg;
                r_point   <= n_point;
                r_frac    <= n_frac;
                r_stopped <= n_stopped;
                r_status  <= n_status;
            end
            if (o_consume && i_dec.is_last) begin
                r_snap_vld <= 1'b1;
            end else if (i_snap_take) begin
                r_snap_vld <= 1'b0;
            end
        end
        if (o_consume && i_dec.is_last) begin
            r_snap.acc        <= n_acc;
            r_snap.overflow   <= n_ovf;
            r_snap.digit_seen <= n_seen;
            r_snap.negative   <= n_neg;
            r_snap.frac       <= n_frac;
            r_snap.status     <= n_status;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

endmodule

`default_nettype wire

[hdl/anp_final.sv]
// ----------------------------------------------------------------------------
// anp_final
// Saturation, sign and width masking of a finished number; result register.
// ----------------------------------------------------------------------------
`default_nettype none

module anp_final
    import anp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire          i_snap_vld,
    input  wire t_snap   i_snap,
    output logic         o_snap_take,
    anp_out_if.source    o_result
);

    logic [TWIDTH_W-1:0] w_eff;
    logic [ACC_W-1:0]    mask_c;
    logic [ACC_W-1:0]    r_mask;
    logic [ACC_W-1:0]    r_max_pos;
    logic [ACC_W-1:0]    r_max_neg;
    logic [ACC_W-1:0]    maxv;
    logic [ACC_W-1:0]    mag;
    logic [ACC_W-1:0]    val;
    logic [STATUS_W-1:0] status;
    logic                r_ov;
    logic [ACC_W-1:0]    r_value;
    logic [FRAC_W-1:0]   r_frac;
    logic                r_ok;
    logic [STATUS_W-1:0] r_status;

    always_comb begin
        w_eff = i_cfg.target_width;
        if (w_eff == '0) begin
            w_eff = TWIDTH_W'(1);
        end else if (w_eff > TWIDTH_W'(MAX_WIDTH)) begin
            w_eff = TWIDTH_W'(MAX_WIDTH);
        end
        if (w_eff >= TWIDTH_W'(ACC_W)) begin
            mask_c = '1;
        end else begin
            mask_c = (ACC_W'(1) << w_eff) - ACC_W'(1);
        end
    end

    // limits follow the configuration, which the user must change only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_mask    <= mask_c;
        r_max_pos <= mask_c >> 1;
        r_max_neg <= (mask_c >> 1) + ACC_W'(1);
    end

    always_comb begin
        status = i_snap.status;
        if (i_cfg.target_signed) begin
            maxv = i_snap.negative ? r_max_neg : r_max_pos;
        end else begin
            maxv = r_mask;
        end
        mag = i_snap.acc;
        if (i_snap.overflow || mag > maxv) begin
            mag    = maxv;
            status = ST_SAT;
        end
        if (i_cfg.target_signed) begin
            val = i_snap.negative ? (ACC_W'(0) - mag) : mag;
        end else if (i_snap.negative) begin
            val    = '0;
            status = ST_NEGU;
        end else begin
            val = mag;
        end
    end

    assign o_snap_take = i_snap_vld && (!r_ov || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!r_ov || o_result.ready) begin
            r_ov <= i_snap_vld;
        end
        if (o_snap_take) begin
            if (!i_snap.digit_seen) begin
                r_value  <= '0;
                r_frac   <= '0;
                r_ok     <= 1'b0;
                r_status <= ST_EMPTY;
            end else begin
                r_value  <= val & r_mask;
                r_frac   <= i_snap.frac;
                r_ok     <= 1'b1;
                r_status <= status;
            end
        end
    end

    assign o_result.valid           = r_ov;
    assign o_result.parsed_value    = r_value;
    assign o_result.fraction_digits = r_frac;
    assign o_result.parse_ok        = r_ok;
    assign o_result.status_code     = r_status;

endmodule

`default_nettype wire

[hdl/ascii_number_parser_top.sv]
// ----------------------------------------------------------------------------
// ascii_number_parser_top
// Streaming ASCII-to-integer parser for any base from 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries the text one character per item, is_last on the final one.
//   o_result carries one item per text: value, fraction digits, ok, status.
//   Configuration (base, target width, signedness, fraction mode) is written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while no text is in flight.
// Throughput and pipeline:
//   One character per cycle, back to back, while i_item.ready stays high.
//   The last character of a text passes through the input register, the
//   accumulator snapshot and the result register; then the result is valid.
//   The accumulator's 64x6 multiply-add is combinational and sets the rate.
// Reset:
//   Clears the parse state and all valid flags; registers return to base 10,
//   32-bit signed target, no fraction.
// Stall:
//   While o_result is held, the three stages fill up; characters that do not
//   end a text keep flowing through the accumulator until a last character
//   finds the snapshot stage occupied, then i_item.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_number_parser_top
    import anp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    anp_in_if.sink               i_item,
    anp_out_if.source            o_result
);

    t_cfg  r_cfg;
    logic  dec_vld;
    t_dec  dec;
    logic  consume;
    logic  snap_vld;
    t_snap snap;
    logic  snap_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.number_base      <= 6'd10;
            r_cfg.target_width     <= 7'd32;
            r_cfg.target_signed    <= 1'b1;
            r_cfg.fraction_allowed <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUMBER_BASE:      r_cfg.number_base      <= i_cfg_data[BASE_W-1:0];
                CFG_TARGET_WIDTH:     r_cfg.target_width     <= i_cfg_data[TWIDTH_W-1:0];
                CFG_TARGET_SIGNED:    r_cfg.target_signed    <= i_cfg_data[0];
                CFG_FRACTION_ALLOWED: r_cfg.fraction_allowed <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    anp_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_item    (i_item),
        .i_consume (consume),
        .o_vld     (dec_vld),
        .o_dec     (dec)
    );

    anp_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_dec_vld   (dec_vld),
        .i_dec       (dec),
        .o_consume   (consume),
        .i_snap_take (snap_take),
        .o_snap_vld  (snap_vld),
        .o_snap      (snap)
    );

    anp_final u_final (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_snap_vld  (snap_vld),
        .i_snap      (snap),
        .o_snap_take (snap_take),
        .o_result    (o_result)
    );

    a_empty_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.status_code == ST_EMPTY) == !o_result.parse_ok))
        else $error("empty status and parse_ok disagree");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.parse_ok) |->
            (o_result.parsed_value == '0 && o_result.fraction_digits == '0))
        else $error("empty result carries data");

    a_negu_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status_code == ST_NEGU) |->
            (o_result.parsed_value == '0 && !r_cfg.target_signed))
        else $error("negative-to-unsigned result not zero");

    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (snap_vld && !snap_take) |=> snap_vld)
        else $error("pending snapshot lost");

endmodule

`default_nettype wire
